### sv/owrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owrs_pkg;

  localparam logic [7:0] CMD_NORMAL_SEARCH = 8'hF0;
  localparam logic [7:0] CMD_ALARM_SEARCH  = 8'hEC;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_CONTINUE = 2'd1,
    OP_PRESENCE = 2'd2,
    OP_PAIR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_RESET    = 2'd0,
    ACT_WRITE    = 2'd1,
    ACT_FINISHED = 2'd2,
    ACT_ABORTED  = 2'd3
  } act_t;

  // Kind of result burst one request word turns into
  typedef enum logic [2:0] {
    BK_RESET     = 3'd0,
    BK_ABORT     = 3'd1,
    BK_CMD       = 3'd2,
    BK_WRITE     = 3'd3,
    BK_WRITE_FIN = 3'd4
  } bk_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] command_code;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } req_t;

  typedef struct packed {
    act_t        action;
    logic        write_value;
    logic        last_of_run;
    logic        found;
    logic [63:0] rom_id;
    logic        all_enumerated;
  } rsp_t;

  typedef struct packed {
    bk_t         kind;
    logic [7:0]  cmd;
    logic        dir;
    logic        found;
    logic [63:0] rom_id;
    logic        all_enumerated;
  } batch_t;

endpackage

`default_nettype wire

### sv/owrs_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module owrs_decide (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire owrs_pkg::req_t  req,
  input  wire logic            batch_ready,
  output logic                 batch_load,
  output owrs_pkg::batch_t     batch
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_PAIR     = 2'd2
  } phase_t;

  logic           held;
  owrs_pkg::req_t held_word;
  logic           fire;
  logic           emit;

  phase_t      phase, phase_next;
  logic [63:0] rom, rom_next;
  logic [7:0]  cmd, cmd_next;
  logic [6:0]  ldp, ldp_next;
  logic [6:0]  lzp, lzp_next;
  logic [6:0]  bitn, bitn_next;
  logic        lds, lds_next;

  logic [6:0]  bn_eff;
  logic [5:0]  pos;
  logic        disc;
  logic        dir;
  logic [63:0] bit_sel;
  logic [63:0] rom_wr;
  logic [6:0]  lzp_wr;

  assign fire      = held && batch_ready;
  assign req_ready = !held || fire;
  assign batch_load = fire && emit;

  // bit slot datapath
  assign bn_eff   = (bitn == 7'd0 || bitn > 7'd64) ? 7'd1 : bitn;
  assign pos      = 6'(bn_eff - 7'd1);
  assign disc     = (held_word.id_bit == held_word.complement_bit);
  assign dir      = !disc ? held_word.id_bit :
                    (bn_eff < ldp) ? rom[pos] : (bn_eff == ldp);
  assign bit_sel  = 64'd1 << pos;
  assign rom_wr   = dir ? (rom | bit_sel) : (rom & ~bit_sel);
  assign lzp_wr   = (disc && !dir) ? bn_eff : lzp;

  always_comb begin
    phase_next = phase;
    rom_next   = rom;
    cmd_next   = cmd;
    ldp_next   = ldp;
    lzp_next   = lzp;
    bitn_next  = bitn;
    lds_next   = lds;
    emit       = 1'b0;
    batch.kind           = owrs_pkg::BK_RESET;
    batch.cmd            = cmd;
    batch.dir            = dir;
    batch.found          = 1'b0;
    batch.rom_id         = rom_wr;
    batch.all_enumerated = lds;
    unique case (held_word.operation)
      owrs_pkg::OP_START: begin
        emit = 1'b1;
        if (held_word.command_code == owrs_pkg::CMD_NORMAL_SEARCH ||
            held_word.command_code == owrs_pkg::CMD_ALARM_SEARCH) begin
          cmd_next   = held_word.command_code;
          ldp_next   = 7'd0;
          lds_next   = 1'b0;
          rom_next   = 64'd0;
          bitn_next  = 7'd1;
          lzp_next   = 7'd0;
          phase_next = PH_PRESENCE;
          batch.kind = owrs_pkg::BK_RESET;
        end else begin
          phase_next = PH_IDLE;
          batch.kind = owrs_pkg::BK_ABORT;
        end
      end
      owrs_pkg::OP_CONTINUE: begin
        if (phase == PH_IDLE) begin
          emit = 1'b1;
          if (lds) begin
            batch.kind = owrs_pkg::BK_ABORT;
          end else begin
            bitn_next  = 7'd1;
            lzp_next   = 7'd0;
            phase_next = PH_PRESENCE;
            batch.kind = owrs_pkg::BK_RESET;
          end
        end
      end
      owrs_pkg::OP_PRESENCE: begin
        if (phase == PH_PRESENCE) begin
          emit = 1'b1;
          if (!held_word.presence) begin
            phase_next = PH_IDLE;
            batch.kind = owrs_pkg::BK_ABORT;
          end else begin
            phase_next = PH_PAIR;
            batch.kind = owrs_pkg::BK_CMD;
          end
        end
      end
      owrs_pkg::OP_PAIR: begin
        if (phase == PH_PAIR) begin
          emit = 1'b1;
          if (held_word.id_bit && held_word.complement_bit) begin
            // no device answered the slot pair
            phase_next = PH_IDLE;
            batch.kind = owrs_pkg::BK_ABORT;
          end else begin
            rom_next  = rom_wr;
            lzp_next  = lzp_wr;
            bitn_next = 7'(bn_eff + 7'd1);
            if (bn_eff == 7'd64) begin
              ldp_next             = lzp_wr;
              lds_next             = (lzp_wr == 7'd0);
              phase_next           = PH_IDLE;
              batch.kind           = owrs_pkg::BK_WRITE_FIN;
              batch.found          = (rom_wr[7:0] != 8'd0);
              batch.all_enumerated = (lzp_wr == 7'd0);
            end else begin
              batch.kind = owrs_pkg::BK_WRITE;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      phase <= PH_IDLE;
      rom   <= 64'd0;
      cmd   <= owrs_pkg::CMD_NORMAL_SEARCH;
      ldp   <= 7'd0;
      lzp   <= 7'd0;
      bitn  <= 7'd1;
      lds   <= 1'b0;
    end else begin
      if (req_ready) begin
        held <= req_valid;
      end
      if (fire) begin
        phase <= phase_next;
        rom   <= rom_next;
        cmd   <= cmd_next;
        ldp   <= ldp_next;
        lzp   <= lzp_next;
        bitn  <= bitn_next;
        lds   <= lds_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      held_word <= req;
    end
  end

`ifndef SYNTH
  a_pair_bitn: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAIR |-> (bitn >= 7'd1 && bitn <= 7'd64))
    else $error("bit number out of range during pair phase");
  a_last_no_hist: assert property (@(posedge clk) disable iff (rst)
    lds |-> ldp == 7'd0)
    else $error("last device flagged with discrepancy history left");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    batch_load && batch.kind == owrs_pkg::BK_WRITE_FIN |=> phase == PH_IDLE)
    else $error("pass finished but phase not idle");
`endif

endmodule

`default_nettype wire

### sv/owrs_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module owrs_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              batch_load,
  input  wire owrs_pkg::batch_t  batch,
  output logic                   batch_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output owrs_pkg::rsp_t         rsp
);

  logic             bvalid;
  owrs_pkg::batch_t b;
  logic [2:0]       idx;
  logic             last_elem;
  logic             take;
  owrs_pkg::rsp_t   word_next;

  always_comb begin
    case (b.kind)
      owrs_pkg::BK_CMD:       last_elem = (idx == 3'd7);
      owrs_pkg::BK_WRITE_FIN: last_elem = (idx == 3'd1);
      default:                last_elem = 1'b1;
    endcase
  end

  assign take        = bvalid && (!rsp_valid || rsp_ready);
  assign batch_ready = !bvalid || (take && last_elem);

  always_comb begin
    word_next.action         = owrs_pkg::ACT_RESET;
    word_next.write_value    = 1'b0;
    word_next.last_of_run    = last_elem;
    word_next.found          = 1'b0;
    word_next.rom_id         = 64'd0;
    word_next.all_enumerated = 1'b0;
    unique case (b.kind)
      owrs_pkg::BK_RESET: begin
        word_next.action = owrs_pkg::ACT_RESET;
      end
      owrs_pkg::BK_ABORT: begin
        word_next.action         = owrs_pkg::ACT_ABORTED;
        word_next.all_enumerated = b.all_enumerated;
      end
      owrs_pkg::BK_CMD: begin
        // command byte goes out lsb first
        word_next.action      = owrs_pkg::ACT_WRITE;
        word_next.write_value = b.cmd[idx];
      end
      owrs_pkg::BK_WRITE: begin
        word_next.action      = owrs_pkg::ACT_WRITE;
        word_next.write_value = b.dir;
      end
      owrs_pkg::BK_WRITE_FIN: begin
        if (idx == 3'd0) begin
          word_next.action      = owrs_pkg::ACT_WRITE;
          word_next.write_value = b.dir;
        end else begin
          word_next.action         = owrs_pkg::ACT_FINISHED;
          word_next.found          = b.found;
          word_next.rom_id         = b.rom_id;
          word_next.all_enumerated = b.all_enumerated;
        end
      end
      default: begin
        word_next.action = owrs_pkg::ACT_RESET;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid    <= 1'b0;
      idx       <= 3'd0;
      rsp_valid <= 1'b0;
    end else begin
      if (batch_ready) begin
        bvalid <= batch_load;
      end
      if (take) begin
        idx <= last_elem ? 3'd0 : 3'(idx + 3'd1);
      end
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_ready && batch_load) begin
      b <= batch;
    end
    if (take) begin
      rsp <= word_next;
    end
  end

`ifndef SYNTH
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !bvalid |-> idx == 3'd0)
    else $error("burst index left over with no burst held");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    bvalid && b.kind != owrs_pkg::BK_CMD |-> idx <= 3'd1)
    else $error("burst index beyond burst length");
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == owrs_pkg::ACT_FINISHED |-> rsp.last_of_run)
    else $error("finished word not marked last of run");
`endif

endmodule

`default_nettype wire

### sv/one_wire_rom_search_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// The request word is registered in the decision stage, its burst descriptor in
// the emitter, and each result word in the emitter's output register. A run is
// one result word for most request words, two for the final bit slot of a pass,
// and eight for an answered presence word (one per command bit).
// Reset (rst, synchronous, active high): idle, empty pipeline, history clear.

module one_wire_rom_search_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire owrs_pkg::req_t   req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output owrs_pkg::rsp_t        rsp
);

  // Two stages. The decision stage registers the request word, works out
  // the next search state and what burst of results it causes, and hands
  // that burst on as one descriptor. The emitter holds it and plays it out
  // one result word a cycle while rsp_ready allows, through its output
  // register, so a new request can be decided as older results still drain.

  owrs_pkg::batch_t batch;
  logic             batch_load;
  logic             batch_ready;

  // decision: discrepancy history, ROM bits, phase
  owrs_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .batch_ready (batch_ready),
    .batch_load  (batch_load),
    .batch       (batch)
  );

  // burst playout: reset, abort, eight command bits, write, write+finish
  owrs_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .batch_load  (batch_load),
    .batch       (batch),
    .batch_ready (batch_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

### test/search_check_pkg.sv
`timescale 1ns / 1ps

package search_check_pkg;
  import owrs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_PAIR     = 2'd2
  } search_phase_t;

  // Shadow of the search engine: keeps its own history and queues the
  // result words each request word should produce.
  class search_tracker;
    logic [63:0]   rom_bits;
    logic [7:0]    cmd_byte;
    logic [6:0]    last_disc;
    logic [6:0]    zero_pick;
    logic [6:0]    bit_no;
    logic          last_dev;
    search_phase_t phase;
    logic          last_dir;
    rsp_t          pending_actions[$];
    int            mismatches;
    int            checked;
    int            finished;
    int            valid_ids;
    int            aborted;

    function new();
      rom_bits   = '0;
      cmd_byte   = CMD_NORMAL_SEARCH;
      last_disc  = '0;
      zero_pick  = '0;
      bit_no     = 7'd1;
      last_dev   = 1'b0;
      phase      = PH_IDLE;
      last_dir   = 1'b0;
      mismatches = 0;
      checked    = 0;
      finished   = 0;
      valid_ids  = 0;
      aborted    = 0;
    endfunction

    function rsp_t make_word(act_t act, logic wv, logic fnd, logic [63:0] id, logic ld);
      rsp_t r;
      r.action         = act;
      r.write_value    = wv;
      r.last_of_run    = 1'b0;
      r.found          = fnd;
      r.rom_id         = id;
      r.all_enumerated = ld;
      return r;
    endfunction

    function rsp_t open_pass();
      bit_no    = 7'd1;
      zero_pick = '0;
      phase     = PH_PRESENCE;
      return make_word(ACT_RESET, 1'b0, 1'b0, '0, 1'b0);
    endfunction

    function rsp_t give_up();
      phase = PH_IDLE;
      return make_word(ACT_ABORTED, 1'b0, 1'b0, '0, last_dev);
    endfunction

    // Returns the number of result words the request word causes
    function int note_request(req_t w);
      rsp_t run[$];
      int   pos;
      int   i;
      logic dir;
      case (w.operation)
        OP_START: begin
          if (w.command_code == CMD_NORMAL_SEARCH || w.command_code == CMD_ALARM_SEARCH) begin
            cmd_byte   = w.command_code;
            last_disc  = '0;
            last_dev   = 1'b0;
            rom_bits   = '0;
            run.push_back(open_pass());
          end else begin
            run.push_back(give_up());
          end
        end
        OP_CONTINUE: begin
          if (phase == PH_IDLE) begin
            if (last_dev) run.push_back(give_up());
            else run.push_back(open_pass());
          end
        end
        OP_PRESENCE: begin
          if (phase == PH_PRESENCE) begin
            if (!w.presence) begin
              run.push_back(give_up());
            end else begin
              for (i = 0; i < 8; i++)
                run.push_back(make_word(ACT_WRITE, cmd_byte[i], 1'b0, '0, 1'b0));
              phase = PH_PAIR;
            end
          end
        end
        default: begin
          if (phase == PH_PAIR) begin
            if (w.id_bit && w.complement_bit) begin
              run.push_back(give_up());
            end else begin
              if (bit_no < 7'd1 || bit_no > 7'd64) bit_no = 7'd1;
              pos = bit_no - 1;
              if (w.id_bit != w.complement_bit) begin
                dir = w.id_bit;
              end else begin
                // discrepancy: follow history below, take 1 at, 0 above
                if (bit_no < last_disc) dir = rom_bits[pos];
                else dir = (bit_no == last_disc);
                if (!dir) zero_pick = bit_no;
              end
              rom_bits[pos] = dir;
              last_dir = dir;
              run.push_back(make_word(ACT_WRITE, dir, 1'b0, '0, 1'b0));
              bit_no = bit_no + 7'd1;
              if (bit_no > 7'd64) begin
                last_disc = zero_pick;
                if (last_disc == '0) last_dev = 1'b1;
                run.push_back(make_word(ACT_FINISHED, 1'b0, |rom_bits[7:0], rom_bits,
                                        last_dev));
                phase = PH_IDLE;
              end
            end
          end
        end
      endcase
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending_actions.push_back(run[i]);
      return run.size();
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] seen);
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
      mismatches++;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_actions.size() == 0) begin
        $display("%0t ns: result word with none expected, action %0d rom_id 0x%016h",
                 $time, got.action, got.rom_id);
        mismatches++;
        return;
      end
      want = pending_actions.pop_front();
      checked++;
      if (want.action == ACT_FINISHED) begin
        finished++;
        if (want.found) valid_ids++;
      end
      if (want.action == ACT_ABORTED) aborted++;
      if (got.action !== want.action)
        flag("action", 64'(want.action), 64'(got.action));
      if (got.write_value !== want.write_value)
        flag("write_value", 64'(want.write_value), 64'(got.write_value));
      if (got.last_of_run !== want.last_of_run)
        flag("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      if (got.found !== want.found)
        flag("found", 64'(want.found), 64'(got.found));
      if (got.rom_id !== want.rom_id) flag("rom_id", want.rom_id, got.rom_id);
      if (got.all_enumerated !== want.all_enumerated)
        flag("all_enumerated", 64'(want.all_enumerated), 64'(got.all_enumerated));
    endfunction
  endclass

endpackage

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import owrs_pkg::*;
  import search_check_pkg::*;

  localparam int RANDOM_WORDS = 400;
  // no handshake for this long means the engine has hung
  localparam int QUIET_LIMIT  = 2000;
  // extra wait once every predicted result word has been seen, for stray extras
  localparam int DRAIN_CYCLES = 20;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  search_tracker tracker = new();

  // calm stretches: no gaps on the request side, no stalls on the result side
  bit calm = 1'b0;
  int ready_hold = 0;
  int busy_words = 0;   // request words that caused at least one result

  // Devices on the simulated bus for the search passes
  logic [63:0] bus_ids [4];
  logic [3:0]  bus_mask  = '0;
  logic [3:0]  bus_alive = '0;

  one_wire_rom_search_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: ready held high or low for random stretches
  always @(negedge clk) begin
    if (calm) begin
      rsp_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_ready  <= 1'b0;
      ready_hold <= gap_len();
    end else begin
      rsp_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  // Every accepted result word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_result(rsp);
  end

  // Present one request word and hold it until taken. Valid is only lowered
  // when a gap follows, so it never drops and rises within one step.
  task automatic put_word(input req_t w);
    int gap;
    int n;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    n = tracker.note_request(w);
    if (n > 0) busy_words++;
  endtask

  task automatic send_req(input op_t op, input logic [7:0] code, input logic pres,
                          input logic idb, input logic cmp);
    req_t w;
    w.operation      = op;
    w.command_code   = code;
    w.presence       = pres;
    w.id_bit         = idb;
    w.complement_bit = cmp;
    put_word(w);
  endtask

  // Any word at all: mostly ignored or aborting, sometimes a restart
  task automatic send_noise();
    logic [31:0] raw;
    raw = $urandom;
    put_word(req_t'(raw[$bits(req_t)-1:0]));
  endtask

  // New bus of one to four devices; some share a long prefix with an
  // earlier one so that discrepancies turn up deep in the id
  task automatic new_bus();
    int k;
    int j;
    int count;
    count    = $urandom_range(1, 4);
    bus_mask = '0;
    for (k = 0; k < count; k++) begin
      if (k > 0 && $urandom_range(0, 1) == 1) begin
        bus_ids[k] = bus_ids[$urandom_range(0, k - 1)];
        j = $urandom_range(8, 63);
        bus_ids[k][j] = ~bus_ids[k][j];
        if ($urandom_range(0, 1) == 1) begin
          j = $urandom_range(0, 63);
          bus_ids[k][j] = ~bus_ids[k][j];
        end
      end else begin
        bus_ids[k] = {$urandom, $urandom};
      end
      // family byte of zero: search completes but the id is not counted
      if ($urandom_range(0, 3) == 0) bus_ids[k][7:0] = 8'h00;
      bus_mask[k] = 1'b1;
    end
  endtask

  // One search pass: start or continue, presence, then the 64 bit pairs
  // as the devices still on the chosen path would answer them
  task automatic run_pass();
    logic [7:0] code;
    int         pos;
    int         k;
    int         pick;
    logic       idb;
    logic       cmp;
    calm = ($urandom_range(0, 4) == 0);
    if (tracker.phase == PH_IDLE) begin
      // continue after the last device: aborts with the enumeration flag set
      if (tracker.last_dev && $urandom_range(0, 3) == 0)
        send_req(OP_CONTINUE, any_byte(), coin(), coin(), coin());
      if (tracker.last_dev || $urandom_range(0, 7) == 0) begin
        new_bus();
        pick = $urandom_range(0, 19);
        if (pick < 9) code = CMD_NORMAL_SEARCH;
        else if (pick < 18) code = CMD_ALARM_SEARCH;
        else code = any_byte();
        send_req(OP_START, code, coin(), coin(), coin());
      end else begin
        send_req(OP_CONTINUE, any_byte(), coin(), coin(), coin());
      end
    end
    bus_alive = bus_mask;
    if (tracker.phase == PH_PRESENCE)
      send_req(OP_PRESENCE, any_byte(), $urandom_range(0, 15) != 0, coin(), coin());
    while (tracker.phase == PH_PAIR) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        send_noise();
      end else if (pick == 1) begin
        // corrupted slot pair
        send_req(OP_PAIR, any_byte(), coin(), coin(), coin());
      end else begin
        // wired-and bus: any device with a 0 pulls the id bit low,
        // any device with a 1 pulls the complement low
        pos = tracker.bit_no - 1;
        idb = 1'b1;
        cmp = 1'b1;
        for (k = 0; k < 4; k++) begin
          if (bus_alive[k]) begin
            if (bus_ids[k][pos]) cmp = 1'b0;
            else idb = 1'b0;
          end
        end
        send_req(OP_PAIR, any_byte(), coin(), idb, cmp);
        // devices that disagree with the written direction drop out
        for (k = 0; k < 4; k++)
          if (bus_ids[k][pos] != tracker.last_dir) bus_alive[k] = 1'b0;
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      pick = $urandom_range(1, 3);
      repeat (pick) send_noise();
    end
  endtask

  initial begin : stimulus
    int start_words;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    // continue straight after reset: empty history, opens a pass
    send_req(OP_CONTINUE, 8'h00, 1'b0, 1'b0, 1'b0);
    // pair and continue while waiting for presence: both ignored
    send_req(OP_PAIR, 8'hFF, 1'b1, 1'b0, 1'b1);
    send_req(OP_CONTINUE, 8'hFF, 1'b1, 1'b1, 1'b1);
    // nobody answered the reset
    send_req(OP_PRESENCE, 8'h00, 1'b0, 1'b0, 1'b0);
    // presence while idle: ignored
    send_req(OP_PRESENCE, 8'hFF, 1'b1, 1'b1, 1'b1);
    // unknown search commands abort
    send_req(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_req(OP_START, 8'hFF, 1'b1, 1'b1, 1'b1);
    // alarm search, eight command bits out
    send_req(OP_START, CMD_ALARM_SEARCH, 1'b0, 1'b0, 1'b0);
    send_req(OP_PRESENCE, 8'hFF, 1'b1, 1'b0, 1'b0);
    // second presence during the pairs: ignored
    send_req(OP_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0);
    // both bits high: no devices left, abort
    send_req(OP_PAIR, 8'h00, 1'b0, 1'b1, 1'b1);
    send_req(OP_CONTINUE, 8'h00, 1'b0, 1'b0, 1'b0);
    send_req(OP_PRESENCE, 8'h00, 1'b1, 1'b0, 1'b0);
    // plain zero, plain one, then a discrepancy
    send_req(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b1);
    send_req(OP_PAIR, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_req(OP_PAIR, 8'h00, 1'b0, 1'b0, 1'b0);
    // continue in the middle of a pass: ignored
    send_req(OP_CONTINUE, 8'h00, 1'b0, 1'b0, 1'b0);
    // normal search restarts a pass under way
    send_req(OP_START, CMD_NORMAL_SEARCH, 1'b1, 1'b1, 1'b1);
    send_req(OP_PRESENCE, 8'h00, 1'b1, 1'b1, 1'b1);
    send_req(OP_PAIR, 8'hFF, 1'b1, 1'b0, 1'b0);

    // Random part: search passes over random buses, with noise between
    new_bus();
    start_words = busy_words;
    while (busy_words - start_words < RANDOM_WORDS) run_pass();
    @(negedge clk);
    req_valid <= 1'b0;
    calm = 1'b0;

    while (tracker.pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request words with results, %0d result words checked",
             busy_words, tracker.checked);
    $display("%0d passes completed (%0d with a nonzero family byte), %0d aborts",
             tracker.finished, tracker.valid_ids, tracker.aborted);
    if (tracker.mismatches == 0 && tracker.pending_actions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: ends the run when no word moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule
